// ===== hdl/mal_pkg.sv =====
// ----------------------------------------------------------------------------
// MAC learning table package
// Types, sizes and codes shared by the learning table modules.
// ----------------------------------------------------------------------------
package mal_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int COUNT_W       = 7;
    localparam int ADDR_W        = 48;
    localparam int TIME_W        = 32;
    localparam int CHAN_W        = 4;

    localparam logic MODE_OBSERVE = 1'b0;
    localparam logic MODE_PRUNE   = 1'b1;

    typedef enum logic [1:0] {
        OUTCOME_REFRESH = 2'd0,
        OUTCOME_INSERT  = 2'd1,
        OUTCOME_EVICT   = 2'd2,
        OUTCOME_PRUNE   = 2'd3
    } outcome_t;

    typedef struct packed {
        logic                mode;
        logic [ADDR_W-1:0]   source_address;
        logic [TIME_W-1:0]   now_ms;
        logic [CHAN_W-1:0]   radio_channel;
    } mal_in_t;

    typedef struct packed {
        outcome_t            outcome;
        logic [ADDR_W-1:0]   evicted_address;
        logic [COUNT_W-1:0]  pruned_count;
        logic [COUNT_W-1:0]  occupancy;
    } mal_out_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [TIME_W-1:0]   last_seen;
        logic [ADDR_W-1:0]   address;
    } mal_entry_t;

    localparam int ENTRY_W = $bits(mal_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } mal_state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_issue;
    } ctrl_status_t;

    function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] value);
        logic [CNT_W+COUNT_W-1:0] wide;
        wide = {{COUNT_W{1'b0}}, value};
        return wide[COUNT_W-1:0];
    endfunction

endpackage

// ===== hdl/mac_address_learning_table.sv =====
// ----------------------------------------------------------------------------
// MAC address learning table
// Bounded table of source addresses with refresh, eviction and aging.
// ----------------------------------------------------------------------------
// Each item reads every table entry once through the single entry RAM read
// port, and busy stays high through the scan, drain and commit states, so a
// new item can be taken only once the last is done, in its strobe cycle.
// The result is shown for one cycle only, since the receiver cannot stall.
// Reset clears all valid bits, the occupancy and the expiry register at once.
module mac_address_learning_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mal_pkg::mal_in_t  item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data,
    output logic              result_strobe,
    output mal_pkg::mal_out_t result
);
    import mal_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    mal_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    mal_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

// ===== hdl/mal_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic                                           re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mal_ctrl.sv =====
// ----------------------------------------------------------------------------
// MAC learning table controller
// Sequences the table scan, the drain of the last read and the commit.
// ----------------------------------------------------------------------------
module mal_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mal_pkg::ctrl_status_t status,
    output mal_pkg::ctrl_cmd_t    cmd
);
    import mal_pkg::*;

    mal_state_t state_reg;
    mal_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/mal_datapath.sv =====
// ----------------------------------------------------------------------------
// MAC learning table datapath
// Entry storage, valid bits, scan evaluation and result formation.
// ----------------------------------------------------------------------------
module mal_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mal_pkg::mal_in_t      item,
    input  logic                  cfg_valid,
    input  logic [31:0]           cfg_data,
    input  mal_pkg::ctrl_cmd_t    cmd,
    output mal_pkg::ctrl_status_t status,
    output logic                  result_strobe,
    output mal_pkg::mal_out_t     result
);
    import mal_pkg::*;

    logic [TIME_W-1:0]        expiry_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg,     valid_next;
    logic [CNT_W-1:0]         occ_reg,       occ_next;
    logic [IDX_W-1:0]         rd_idx_reg,    rd_idx_next;
    logic [IDX_W-1:0]         eval_idx_reg,  eval_idx_next;
    logic                     eval_vld_reg,  eval_vld_next;
    logic                     hit_reg,       hit_next;
    logic [IDX_W-1:0]         hit_idx_reg,   hit_idx_next;
    logic [CHAN_W-1:0]        hit_chan_reg,  hit_chan_next;
    logic                     min_found_reg, min_found_next;
    logic [IDX_W-1:0]         min_idx_reg,   min_idx_next;
    logic [ADDR_W-1:0]        min_addr_reg,  min_addr_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg,  free_idx_next;
    logic [CNT_W-1:0]         removed_reg,   removed_next;
    mal_in_t                  item_reg,      item_next;
    logic [TIME_W-1:0]        limit_reg,     limit_next;
    logic                     prune_en_reg,  prune_en_next;
    logic                     strobe_reg,    strobe_next;
    mal_out_t                 result_reg,    result_next;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    mal_entry_t               ram_wdata;
    logic [ENTRY_W-1:0]       ram_rdata;
    mal_entry_t               rd_entry;
    logic                     cur_valid;
    logic                     table_full;

    mal_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry          = mal_entry_t'(ram_rdata);
    assign cur_valid         = valid_reg[eval_idx_reg];
    assign table_full        = (occ_reg == CNT_W'(TABLE_ENTRIES));
    assign status.last_issue = (rd_idx_reg == IDX_W'(TABLE_ENTRIES - 1));

    always_comb
    begin
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        rd_idx_next     = rd_idx_reg;
        eval_idx_next   = eval_idx_reg;
        eval_vld_next   = cmd.issue;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_chan_next   = hit_chan_reg;
        min_found_next  = min_found_reg;
        min_idx_next    = min_idx_reg;
        min_addr_next   = min_addr_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        removed_next    = removed_reg;
        item_next       = item_reg;
        limit_next      = limit_reg;
        prune_en_next   = prune_en_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata.channel   = item_reg.radio_channel;
        ram_wdata.last_seen = item_reg.now_ms;
        ram_wdata.address   = item_reg.source_address;

        if (cmd.load)
        begin
            item_next       = item;
            limit_next      = item.now_ms - expiry_reg;
            prune_en_next   = (expiry_reg != '0);
            rd_idx_next     = '0;
            hit_next        = 1'b0;
            min_found_next  = 1'b0;
            free_found_next = 1'b0;
            removed_next    = '0;
        end

        if (cmd.issue)
        begin
            rd_idx_next   = rd_idx_reg + 1'b1;
            eval_idx_next = rd_idx_reg;
        end

        if (eval_vld_reg)
        begin
            if (item_reg.mode == MODE_PRUNE)
            begin
                if (cur_valid && prune_en_reg && (rd_entry.last_seen < limit_reg))
                begin
                    valid_next[eval_idx_reg] = 1'b0;
                    removed_next             = removed_reg + 1'b1;
                end
            end
            else
            begin
                if (cur_valid && !hit_reg && (rd_entry.address == item_reg.source_address))
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = eval_idx_reg;
                    hit_chan_next = rd_entry.channel;
                end
                if (cur_valid && (!min_found_reg || (rd_entry.address < min_addr_reg)))
                begin
                    min_found_next = 1'b1;
                    min_idx_next   = eval_idx_reg;
                    min_addr_next  = rd_entry.address;
                end
                if (!cur_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = eval_idx_reg;
                end
            end
        end

        if (cmd.commit)
        begin
            strobe_next                 = 1'b1;
            result_next.evicted_address = '0;
            result_next.pruned_count    = '0;
            if (item_reg.mode == MODE_PRUNE)
            begin
                occ_next                 = occ_reg - removed_reg;
                result_next.outcome      = OUTCOME_PRUNE;
                result_next.pruned_count = to_count(removed_reg);
                result_next.occupancy    = to_count(occ_reg - removed_reg);
            end
            else if (hit_reg)
            begin
                ram_we                = 1'b1;
                ram_waddr             = hit_idx_reg;
                ram_wdata.channel     = hit_chan_reg;
                result_next.outcome   = OUTCOME_REFRESH;
                result_next.occupancy = to_count(occ_reg);
            end
            else if (table_full)
            begin
                ram_we                      = 1'b1;
                ram_waddr                   = min_idx_reg;
                result_next.outcome         = OUTCOME_EVICT;
                result_next.evicted_address = min_addr_reg;
                result_next.occupancy       = to_count(occ_reg);
            end
            else
            begin
                ram_we                   = 1'b1;
                ram_waddr                = free_idx_reg;
                valid_next[free_idx_reg] = 1'b1;
                occ_next                 = occ_reg + 1'b1;
                result_next.outcome      = OUTCOME_INSERT;
                result_next.occupancy    = to_count(occ_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg     <= '0;
            valid_reg      <= '0;
            occ_reg        <= '0;
            eval_vld_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            min_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            removed_reg    <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                expiry_reg <= cfg_data;
            end
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            eval_vld_reg   <= eval_vld_next;
            hit_reg        <= hit_next;
            min_found_reg  <= min_found_next;
            free_found_reg <= free_found_next;
            removed_reg    <= removed_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        eval_idx_reg  <= eval_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_chan_reg  <= hit_chan_next;
        min_idx_reg   <= min_idx_next;
        min_addr_reg  <= min_addr_next;
        free_idx_reg  <= free_idx_next;
        item_reg      <= item_next;
        limit_reg     <= limit_next;
        prune_en_reg  <= prune_en_next;
        result_reg    <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

// ===== dv/mac_address_learning_table_tb.sv =====
// ----------------------------------------------------------------------------
// MAC address learning table testbench
// Drives observe and prune commands with directed and random content, keeps a
// shadow copy of the table with its aging register, and checks every result
// strobe field by field against the shadow outcome.
// ----------------------------------------------------------------------------

module mac_address_learning_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mal_pkg::*;

    class table_scoreboard;

        bit                             slot_valid   [mal_pkg::TABLE_ENTRIES];
        logic [mal_pkg::ADDR_W-1:0]     slot_address [mal_pkg::TABLE_ENTRIES];
        logic [mal_pkg::TIME_W-1:0]     slot_seen    [mal_pkg::TABLE_ENTRIES];
        logic [mal_pkg::CHAN_W-1:0]     slot_channel [mal_pkg::TABLE_ENTRIES];
        logic [mal_pkg::TIME_W-1:0]     expiry_ms;
        mal_pkg::mal_out_t              expected_outcomes[$];
        int                             mismatches;
        int                             results_seen;
        int                             outcome_tally[4];
        int                             entries_aged_out;

        function new();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            expiry_ms        = '0;
            mismatches       = 0;
            results_seen     = 0;
            entries_aged_out = 0;
            foreach (outcome_tally[i]) outcome_tally[i] = 0;
        endfunction

        function void set_expiry(logic [mal_pkg::TIME_W-1:0] value);
            expiry_ms = value;
        endfunction

        function int occupied_slots();
            int used;
            used = 0;
            foreach (slot_valid[i]) if (slot_valid[i]) used++;
            return used;
        endfunction

        function void predict_lookup(mal_pkg::mal_in_t it);
            mal_pkg::mal_out_t          want;
            logic [mal_pkg::TIME_W-1:0] age_limit;
            logic [6:0]                 removed;
            int                         hit_slot;
            int                         victim;
            int                         free_slot;
            want     = '0;
            removed  = '0;
            hit_slot = -1;
            victim   = -1;
            free_slot = -1;
            if (it.mode == mal_pkg::MODE_PRUNE) begin
                want.outcome = mal_pkg::OUTCOME_PRUNE;
                if (expiry_ms != 0) begin
                    age_limit = it.now_ms - expiry_ms;
                    for (int i = 0; i < mal_pkg::TABLE_ENTRIES; i++) begin
                        if (slot_valid[i] && slot_seen[i] < age_limit) begin
                            slot_valid[i] = 1'b0;
                            removed++;
                        end
                    end
                end
                want.pruned_count = removed;
            end else begin
                for (int i = 0; i < mal_pkg::TABLE_ENTRIES; i++) begin
                    if (slot_valid[i] && slot_address[i] == it.source_address) begin
                        hit_slot = i;
                        break;
                    end
                end
                if (hit_slot >= 0) begin
                    slot_seen[hit_slot] = it.now_ms;
                    want.outcome = mal_pkg::OUTCOME_REFRESH;
                end else begin
                    want.outcome = mal_pkg::OUTCOME_INSERT;
                    if (occupied_slots() >= mal_pkg::TABLE_ENTRIES) begin
                        for (int i = 0; i < mal_pkg::TABLE_ENTRIES; i++) begin
                            if (slot_valid[i] &&
                                (victim < 0 || slot_address[i] < slot_address[victim]))
                                victim = i;
                        end
                        if (victim >= 0) begin
                            want.outcome         = mal_pkg::OUTCOME_EVICT;
                            want.evicted_address = slot_address[victim];
                            slot_valid[victim]   = 1'b0;
                        end
                    end
                    for (int i = 0; i < mal_pkg::TABLE_ENTRIES; i++) begin
                        if (!slot_valid[i]) begin
                            free_slot = i;
                            break;
                        end
                    end
                    if (free_slot >= 0) begin
                        slot_valid[free_slot]   = 1'b1;
                        slot_address[free_slot] = it.source_address;
                        slot_seen[free_slot]    = it.now_ms;
                        slot_channel[free_slot] = it.radio_channel;
                    end
                end
            end
            want.occupancy = 7'(occupied_slots());
            expected_outcomes.push_back(want);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at time %0t, result %0d: %s", $realtime, results_seen,
                         what);
        endtask

        task check_result(mal_pkg::mal_out_t got);
            mal_pkg::mal_out_t want;
            if (expected_outcomes.size() == 0) begin
                report_mismatch("result strobe with no command outstanding");
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.outcome !== want.outcome)
                report_mismatch($sformatf("outcome %0d, expected %0d",
                                          got.outcome, want.outcome));
            if (got.evicted_address !== want.evicted_address)
                report_mismatch($sformatf("evicted_address %h, expected %h",
                                          got.evicted_address, want.evicted_address));
            if (got.pruned_count !== want.pruned_count)
                report_mismatch($sformatf("pruned_count %0d, expected %0d",
                                          got.pruned_count, want.pruned_count));
            if (got.occupancy !== want.occupancy)
                report_mismatch($sformatf("occupancy %0d, expected %0d",
                                          got.occupancy, want.occupancy));
            outcome_tally[want.outcome]++;
            entries_aged_out += want.pruned_count;
            results_seen++;
        endtask

    endclass

    localparam int CLK_PERIOD  = 12;
    localparam int POOL_SIZE   = 96;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 200;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    mal_in_t            item      = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [31:0]        cfg_data  = '0;
    logic               result_strobe;
    mal_out_t           result;

    table_scoreboard    sb = new();
    logic [ADDR_W-1:0]  address_pool[POOL_SIZE];
    logic [TIME_W-1:0]  clock_ms = '0;

    mac_address_learning_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .result        (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && result_strobe)
            sb.check_result(result);
    end

    function automatic logic [ADDR_W-1:0] random_address();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[ADDR_W-1:0];
    endfunction

    function automatic mal_in_t make_item(logic mode, logic [ADDR_W-1:0] addr,
                                          logic [TIME_W-1:0] now,
                                          logic [CHAN_W-1:0] chan);
        mal_in_t it;
        it.mode           = mode;
        it.source_address = addr;
        it.now_ms         = now;
        it.radio_channel  = chan;
        return it;
    endfunction

    function automatic mal_in_t random_item();
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [CHAN_W-1:0] chan;
        mode = ($urandom_range(0, 99) < 12) ? MODE_PRUNE : MODE_OBSERVE;
        if ($urandom_range(0, 3) == 0)
            addr = random_address();
        else
            addr = address_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 19) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 60);
        if ($urandom_range(0, 9) == 0)
            chan = CHAN_W'($urandom_range(0, 15));
        else
            chan = CHAN_W'($urandom_range(1, 14));
        return make_item(mode, addr, clock_ms, chan);
    endfunction

    task automatic send_item(mal_in_t it, bit idling);
        if (idling && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.predict_lookup(it);
    endtask

    task automatic wait_for_results();
        while (sb.expected_outcomes.size() != 0) @(posedge clk);
    endtask

    task automatic write_expiry(logic [31:0] value);
        repeat ($urandom_range(1, 10)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_expiry(value);
    endtask

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [31:0] expiry;
        bit          idling;

        address_pool[0] = '0;
        address_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            address_pool[i] = (i < 32) ? 48'h001A_2B00_0000 + i : random_address();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Expiry still at its reset value of zero, so the prune here is disabled.
        send_item(make_item(MODE_OBSERVE, '0, '0, 4'd0), 1'b0);
        send_item(make_item(MODE_OBSERVE, '1, '1, 4'd15), 1'b0);
        send_item(make_item(MODE_OBSERVE, '0, 32'd5, 4'd1), 1'b0);
        send_item(make_item(MODE_PRUNE, '1, '1, 4'd7), 1'b0);
        send_item(make_item(MODE_OBSERVE, 48'h8000_0000_0000, 32'd10, 4'd14), 1'b0);
        send_item(make_item(MODE_OBSERVE, 48'h0000_0000_0001, 32'd20, 4'd8), 1'b0);
        start <= 1'b0;
        wait_for_results();
        write_expiry(32'd1);
        send_item(make_item(MODE_PRUNE, '0, 32'd21, 4'd3), 1'b0);
        send_item(make_item(MODE_PRUNE, random_address(), '0, 4'd3), 1'b0);
        send_item(make_item(MODE_OBSERVE, '1, '0, 4'd2), 1'b0);
        start <= 1'b0;
        wait_for_results();
        write_expiry('1);
        send_item(make_item(MODE_PRUNE, '0, '0, 4'd9), 1'b0);
        send_item(make_item(MODE_OBSERVE, 48'h7FFF_FFFF_FFFF, 32'h8000_0000, 4'd15), 1'b0);
        send_item(make_item(MODE_PRUNE, '0, 32'h8000_0000, 4'd0), 1'b0);
        start <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_for_results();
            case (p)
                0: expiry = 32'd0;
                1: expiry = $urandom_range(100, 3000);
                2: expiry = 32'hFFFF_FFFF;
                3: expiry = $urandom_range(1000, 100000);
                4: expiry = $urandom;
                5: expiry = 32'd1;
                6: expiry = 32'd0;
                default: expiry = $urandom_range(200, 2000);
            endcase
            write_expiry(expiry);
            idling = (p != 3) && (p != NUM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item(), idling);
            start <= 1'b0;
        end

        wait_for_results();
        repeat (TABLE_ENTRIES + 10) @(posedge clk);
        if (sb.expected_outcomes.size() != 0)
            sb.report_mismatch("results still outstanding at the end of the run");

        $display("Checked %0d results over %0d aging settings: %0d refreshes, %0d inserts,",
                 sb.results_seen, NUM_PHASES + 3, sb.outcome_tally[OUTCOME_REFRESH],
                 sb.outcome_tally[OUTCOME_INSERT]);
        $display("%0d evictions and %0d prunes that aged out %0d entries.",
                 sb.outcome_tally[OUTCOME_EVICT], sb.outcome_tally[OUTCOME_PRUNE],
                 sb.entries_aged_out);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== mac_address_learning_table.f =====
hdl/mal_pkg.sv
hdl/mal_ram.sv
hdl/mal_ctrl.sv
hdl/mal_datapath.sv
hdl/mac_address_learning_table.sv
dv/mac_address_learning_table_tb.sv
